// File: rtl/tts_pkg.sv
// Package for the thermocouple thermostat sequencer: sequencer states, phase
// and register codes, fixed-point constants, divider widths and the divider
// status struct. No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

  // parameter defaults
  localparam int OFFSET_SAMPLES_DEF = 21;
  localparam int POLY_DEGREE_DEF    = 5;

  // fixed-point constants
  localparam logic signed [31:0] MV_FACTOR = 32'sd10872;   // 6.48e-4 * 2^24
  localparam logic signed [31:0] CJ_FACTOR = 32'sd930923;  // 13.87183e-3 * 64 * 2^20
  localparam logic signed [43:0] KELVIN_64 = 44'sd17472;   // 273 * 64
  localparam logic [63:0]        CJ_ROUND  = 64'd524288;   // 2^19

  // serial divider sizes
  localparam int DIV_NW = 25;   // dividend / quotient bits
  localparam int DIV_DW = 15;   // divisor bits

  // reading sequence
  localparam logic [1:0] PH_OFS = 2'd0;
  localparam logic [1:0] PH_TC  = 2'd1;
  localparam logic [1:0] PH_SP  = 2'd2;
  localparam logic [1:0] PH_CJ  = 2'd3;

  // register map
  localparam logic [2:0] REG_COEF_1    = 3'd0;
  localparam logic [2:0] REG_COEF_2    = 3'd1;
  localparam logic [2:0] REG_COEF_3    = 3'd2;
  localparam logic [2:0] REG_COEF_4    = 3'd3;
  localparam logic [2:0] REG_COEF_5    = 3'd4;
  localparam logic [2:0] REG_SPAN      = 3'd5;
  localparam logic [2:0] REG_FULL_SCALE = 3'd6;
  localparam logic [2:0] REG_HYST      = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OFSMUL,
    S_OFSGET,
    S_EMUL,
    S_EGET,
    S_HMUL,
    S_HADD,
    S_FMUL,
    S_FGET,
    S_HEAT,
    S_SPMUL,
    S_DIVGO,
    S_DIVWAIT,
    S_CJMUL,
    S_CJGET,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/thermocouple_thermostat_sequencer.sv
// Top level of the thermocouple thermostat sequencer: register file, reading
// sequencer and datapath. Uses tts_pkg, tts_mul and tts_div.
`timescale 1ns / 1ps

// One ADC conversion is taken per transfer; the block then works on it alone
// with in_stall high and returns exactly one result. After reset the first
// OFFSET_SAMPLES conversions are shorted-input readings averaged into an offset;
// after that the readings cycle thermocouple, setpoint knob, cold junction.
// Work per item, with D = POLY_DEGREE: offset readings are accumulated, the
// last one also takes a reciprocal multiply; thermocouple runs the shared
// 32x32 multiplier D+1 times (Horner form); setpoint takes one multiply then
// the 25-bit serial divider, and a negative knob reading skips both; cold
// junction takes one multiply. The result waits in an output register, so a
// new conversion is taken while the previous result is still stalled.
// Configuration (cfg_ready is always high) should be written while idle.

module thermocouple_thermostat_sequencer #(
  parameter int OFFSET_SAMPLES = tts_pkg::OFFSET_SAMPLES_DEF,  // 1..31
  parameter int POLY_DEGREE    = tts_pkg::POLY_DEGREE_DEF      // 1..5
) (
  input  logic               clk,
  input  logic               rst,
  // conversion input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic               heater_on,
  output logic [1:0]         phase_done,
  output logic signed [17:0] temperature,
  output logic [10:0]        setpoint_now,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tts_pkg::*;

  // offset average: |sum| < 2^20, so ceil(2^26/N) gives the exact quotient
  localparam int OFS_SHIFT = 26;
  localparam int OFS_RECIP = ((1 << OFS_SHIFT) + OFFSET_SAMPLES - 1) / OFFSET_SAMPLES;

  // ---------------------------------------------------------------- config
  logic signed [31:0] coef [5];
  logic [9:0]         span;
  logic [14:0]        full_scale;
  logic [7:0]         hyst;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0]    <= 32'sd26302009;
      coef[1]    <= '0;
      coef[2]    <= '0;
      coef[3]    <= '0;
      coef[4]    <= '0;
      span       <= 10'd200;
      full_scale <= 15'd30185;
      hyst       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4, REG_COEF_5: begin
          coef[cfg_index] <= cfg_data;
        end
        REG_SPAN:       span       <= cfg_data[9:0];
        REG_FULL_SCALE: full_scale <= cfg_data[14:0];
        REG_HYST:       hyst       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  seq_state_t state, state_next;

  logic [1:0]         phase;
  logic [1:0]         done_phase;
  logic [4:0]         offset_count;
  logic signed [20:0] offset_sum;
  logic signed [15:0] offset_value;
  logic [10:0]        sp_store;
  logic signed [17:0] cj_store;
  logic signed [17:0] temp_store;
  logic               heater_state;

  logic signed [15:0] s;      // latched conversion
  logic signed [31:0] e_mv;   // millivolts, Q7.24
  logic signed [31:0] acc;    // Horner accumulator, Q11.20
  logic [2:0]         hcnt;   // Horner steps left

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  tts_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // serial divider for the setpoint
  logic [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0] div_d;
  logic [DIV_NW-1:0] quot;
  div_stat_t         div_stat;
  logic [20:0]       sum_mag;

  assign sum_mag = offset_sum[20] ? 21'(-offset_sum) : offset_sum;
  assign div_n   = prod[DIV_NW-1:0];
  assign div_d   = full_scale;

  tts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVGO),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (quot),
    .stat     (div_stat)
  );

  logic in_xfer;
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // ---------------------------------------------------------------- datapath
  logic signed [16:0] s_less_ofs;
  logic signed [40:0] horner_sum;
  logic signed [31:0] horner_sat;
  logic signed [26:0] temp_sum;
  logic signed [17:0] temp_sat;
  logic signed [63:0] cj_rnd;
  logic signed [43:0] cj_sum;
  logic signed [17:0] cj_sat;
  logic [17:0]        hi_lim;
  logic [16:0]        lo_lim;
  logic [15:0]        ofs_q;

  assign s_less_ofs = 17'(s) - 17'(offset_value);
  assign horner_sum = 41'(coef[hcnt - 3'd1]) + 41'($signed(prod[63:24]));
  assign horner_sat = (horner_sum > 41'sd2147483647)  ? 32'sh7FFFFFFF :
                      (horner_sum < -41'sd2147483648) ? 32'sh80000000 :
                      horner_sum[31:0];
  assign temp_sum   = 27'($signed(prod[63:38])) + 27'(cj_store);
  assign temp_sat   = (temp_sum > 27'sd131071)  ? 18'sh1FFFF :
                      (temp_sum < -27'sd131072) ? 18'sh20000 : temp_sum[17:0];
  assign cj_rnd     = prod + $signed(CJ_ROUND);
  assign cj_sum     = cj_rnd[63:20] - KELVIN_64;
  assign cj_sat     = (cj_sum > 44'sd131071)  ? 18'sh1FFFF :
                      (cj_sum < -44'sd131072) ? 18'sh20000 : cj_sum[17:0];
  assign hi_lim     = 18'({1'b0, sp_store} + {4'b0, hyst}) << 6;
  assign lo_lim     = {sp_store, 6'b0};
  assign ofs_q      = prod[OFS_SHIFT+15:OFS_SHIFT];

  // multiplier operand select
  always_comb begin
    mul_a = acc;
    mul_b = e_mv;
    case (state)
      S_OFSMUL: begin
        mul_a = 32'(sum_mag);
        mul_b = 32'(OFS_RECIP);
      end
      S_EMUL: begin
        mul_a = 32'(s_less_ofs);
        mul_b = MV_FACTOR;
      end
      S_SPMUL: begin
        mul_a = {22'b0, span};
        mul_b = 32'(s);
      end
      S_CJMUL: begin
        mul_a = 32'(s);
        mul_b = CJ_FACTOR;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (phase)
            PH_OFS: state_next = (32'(offset_count) + 1 >= OFFSET_SAMPLES) ? S_OFSMUL : S_OUT;
            PH_TC:  state_next = S_EMUL;
            PH_SP:  state_next = sample[15] ? S_OUT : S_SPMUL;
            PH_CJ:  state_next = S_CJMUL;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_OFSMUL:  state_next = S_OFSGET;
      S_OFSGET:  state_next = S_OUT;
      S_EMUL:    state_next = S_EGET;
      S_EGET:    state_next = (POLY_DEGREE > 1) ? S_HMUL : S_FMUL;
      S_HMUL:    state_next = S_HADD;
      S_HADD:    state_next = (hcnt == 3'd1) ? S_FMUL : S_HMUL;
      S_FMUL:    state_next = S_FGET;
      S_FGET:    state_next = S_HEAT;
      S_HEAT:    state_next = S_OUT;
      S_SPMUL:   state_next = S_DIVGO;
      S_DIVGO:   state_next = S_DIVWAIT;
      S_DIVWAIT: state_next = div_stat.done ? S_OUT : S_DIVWAIT;
      S_CJMUL:   state_next = S_CJGET;
      S_CJGET:   state_next = S_OUT;
      S_OUT:     state_next = (!out_valid || !out_stall) ? S_IDLE : S_OUT;
      default:   state_next = S_IDLE;
    endcase
  end

  // sequencer-owned registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_OFS;
      offset_count <= '0;
      offset_sum   <= '0;
      offset_value <= '0;
      sp_store     <= '0;
      cj_store     <= '0;
      temp_store   <= '0;
      heater_state <= 1'b0;
      done_phase   <= PH_OFS;
      hcnt         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            done_phase <= phase;
            if (phase == PH_OFS) begin
              offset_sum <= offset_sum + 21'(sample);
              if (32'(offset_count) + 1 < OFFSET_SAMPLES) offset_count <= offset_count + 1'b1;
            end else if (phase == PH_SP && sample[15]) begin
              sp_store <= '0;
              phase    <= PH_CJ;
            end
          end
        end
        S_OFSGET: begin
          // truncate toward zero: divide the magnitude, restore the sign
          offset_value <= offset_sum[20] ? 16'(-ofs_q) : ofs_q;
          offset_sum   <= '0;
          offset_count <= '0;
          phase        <= PH_TC;
        end
        S_EGET: hcnt <= 3'(POLY_DEGREE - 1);
        S_HADD: hcnt <= hcnt - 3'd1;
        S_FGET: temp_store <= temp_sat;
        S_HEAT: begin
          // off above setpoint + hysteresis, on below setpoint, else hold
          if (temp_store > $signed({1'b0, hi_lim}))      heater_state <= 1'b0;
          else if (temp_store < $signed({2'b0, lo_lim})) heater_state <= 1'b1;
          phase <= PH_SP;
        end
        S_DIVWAIT: begin
          if (div_stat.done) begin
            sp_store <= (quot > DIV_NW'(2047)) ? 11'd2047 : quot[10:0];
            phase    <= PH_CJ;
          end
        end
        S_CJGET: begin
          cj_store <= cj_sat;
          phase    <= PH_TC;
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (in_xfer) s <= sample;
    if (state == S_EGET) begin
      e_mv <= prod[31:0];
      acc  <= coef[3'(POLY_DEGREE - 1)];
    end
    if (state == S_HADD) acc <= horner_sat;
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      heater_on    <= heater_state;
      phase_done   <= done_phase;
      temperature  <= temp_store;
      setpoint_now <= sp_store;
    end
  end

  // ---------------------------------------------------------------- checks
  a_div_only_waiting: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIVWAIT))
    else $error("divider busy outside its wait state");

  a_cj_then_tc: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && phase == PH_CJ) |-> ##3 (phase == PH_TC))
    else $error("cold junction reading not followed by thermocouple");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(offset_count) < OFFSET_SAMPLES))
    else $error("offset count out of range");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_valid) |=> out_valid)
    else $error("result not posted");

endmodule

// File: rtl/tts_mul.sv
// Shared signed 32x32 multiplier with registered product.
// Depends on nothing beyond the operands it is handed.
`timescale 1ns / 1ps

module tts_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

// File: rtl/tts_div.sv
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Uses tts_pkg for widths and the status struct. Divisor zero gives all ones.
`timescale 1ns / 1ps

module tts_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tts_pkg::DIV_NW-1:0] dividend,
  input  logic [tts_pkg::DIV_DW-1:0] divisor,
  output logic [tts_pkg::DIV_NW-1:0] quotient,
  output tts_pkg::div_stat_t         stat
);
  import tts_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] num;
  logic [DIV_DW:0]   rem;
  logic [DIV_DW-1:0] den;
  logic [CW-1:0]     cnt;
  logic [DIV_DW+1:0] trial;
  logic              ge;

  assign trial = {rem, num[DIV_NW-1]};
  assign ge    = trial >= {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CW'(DIV_NW);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (stat.busy) begin
      rem <= ge ? (DIV_DW+1)'(trial - {2'b00, den}) : trial[DIV_DW:0];
      num <= {num[DIV_NW-2:0], ge};
    end
  end

  assign quotient = num;

endmodule

// File: bench/thermocouple_thermostat_sequencer_tb.sv
// Testbench for thermocouple_thermostat_sequencer: directed table, then random
// conversions under several register settings, checked by a built-in predictor.
// Depends on tts_pkg and the RTL of the block.
`timescale 1ns / 1ps

module thermocouple_thermostat_sequencer_tb;
  import tts_pkg::*;

  localparam int NUM_OFS     = 21;    // offset readings after reset
  localparam int NUM_DIR     = 27;    // rows in the directed table
  localparam int RAND_PER    = 170;   // random conversions per register setting
  localparam int NUM_SETTING = 6;
  localparam int WDOG_LIMIT  = 5000;  // cycles without any transfer
  localparam longint T_HI    = 131071;
  localparam longint T_LO    = -131072;

  typedef struct packed {
    logic               heater;
    logic [1:0]         ph;
    logic signed [17:0] temp;
    logic [10:0]        setp;
  } reading_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] sample;
  logic               out_valid;
  logic               out_stall;
  logic               heater_on;
  logic [1:0]         phase_done;
  logic signed [17:0] temperature;
  logic [10:0]        setpoint_now;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  thermocouple_thermostat_sequencer dut (.*);

  // Predictor copy of the registers.
  logic signed [31:0] m_coef [5];
  logic [9:0]         m_span;
  logic [14:0]        m_fsc;
  logic [7:0]         m_hyst;

  // Predictor copy of the sequencer state.
  logic [1:0]         m_phase;
  int                 m_ofs_cnt;
  int                 m_ofs_sum;
  int                 m_ofs_val;
  int                 m_setp;
  int                 m_cold;
  int                 m_temp;
  logic               m_heater;

  reading_t pending_readings[$];
  int       mismatches;
  int       idle_cycles;
  bit       no_gaps;    // stretch with no idling on either side

  // Directed conversions: 21 offset readings, then two full rounds of the
  // thermocouple / knob / cold-junction cycle at the input extremes.
  localparam logic [15:0] DIR_SAMPLES [NUM_DIR] = '{
    16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa,
    16'h0010, 16'hfff0, 16'h0100, 16'hff00, 16'h1234, 16'hedcc, 16'h0000,
    16'h7fff, 16'h8000, 16'h0003, 16'hfffd, 16'h0002, 16'hfffe, 16'h0007,
    16'h7fff, 16'h7fff, 16'h8000,   // tc max, knob max, cj min
    16'h8000, 16'hffff, 16'h7fff    // tc min, knob negative, cj max
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Expected result for one accepted conversion; advances the predictor state.
  function automatic reading_t thermostat_step(logic signed [15:0] s_in);
    reading_t r;
    longint   s;
    longint   mv;
    longint   acc;
    longint   t;
    s = s_in;
    r.ph = m_phase;
    case (m_phase)
      PH_OFS: begin
        m_ofs_sum += int'(s);
        if (m_ofs_cnt + 1 >= NUM_OFS) begin
          m_ofs_val = m_ofs_sum / NUM_OFS;   // truncates toward zero
          m_ofs_sum = 0;
          m_ofs_cnt = 0;
          m_phase   = PH_TC;
        end else begin
          m_ofs_cnt++;
        end
      end
      PH_TC: begin
        mv  = (s - m_ofs_val) * 10872;        // Q7.24 millivolts
        acc = m_coef[4];
        for (int k = 3; k >= 0; k--) begin
          acc = longint'(m_coef[k]) + ((acc * mv) >>> 24);
          acc = clamp(acc, -64'sd2147483648, 64'sd2147483647);
        end
        t = longint'(m_cold) + ((acc * mv) >>> 38);
        m_temp = int'(clamp(t, T_LO, T_HI));
        if (longint'(m_temp) > (longint'(m_setp) + longint'(m_hyst)) * 64)
          m_heater = 1'b0;
        else if (longint'(m_temp) < longint'(m_setp) * 64)
          m_heater = 1'b1;
        m_phase = PH_SP;
      end
      PH_SP: begin
        if (s < 0)
          m_setp = 0;
        else if (m_fsc == 0)
          m_setp = 2047;
        else
          m_setp = int'(clamp((longint'(m_span) * s) / longint'(m_fsc), 0, 2047));
        m_phase = PH_CJ;
      end
      default: begin
        t = ((s * 930923 + 524288) >>> 20) - 17472;
        m_cold  = int'(clamp(t, T_LO, T_HI));
        m_phase = PH_TC;
      end
    endcase
    r.heater = m_heater;
    r.temp   = m_temp[17:0];
    r.setp   = m_setp[10:0];
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1, 2, 3: return 16'($urandom);
      4:       return -16'($urandom_range(0, 300));
      default: return 16'($urandom_range(0, 20000));
    endcase
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPAN:       m_span = data[9:0];
      REG_FULL_SCALE: m_fsc  = data[14:0];
      REG_HYST:       m_hyst = data[7:0];
      default:        m_coef[idx] = data;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One conversion transfer; the expectation is queued at the accepting edge.
  task automatic send_sample(logic [15:0] s, bit typed, reading_t typed_exp);
    reading_t r;
    repeat (pick_gap()) @(negedge clk);
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    r = thermostat_step(s);
    pending_readings.push_back(typed ? typed_exp : r);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);   // covers the slowest item of the block
  endtask

  // Register settings per round of random conversions, extremes among them.
  task automatic apply_setting(int n);
    logic [31:0] c [5];
    logic [31:0] span;
    logic [31:0] fsc;
    logic [31:0] hyst;
    c = '{32'd26302009, 32'd0, 32'd0, 32'd0, 32'd0};
    span = 200; fsc = 30185; hyst = 0;
    case (n)
      1: begin   // small knob scale: setpoint saturates, heater rarely off
        c[0] = $urandom_range(0, 1 << 26);
        c[1] = 32'($signed($urandom) >>> 8);
        c[2] = 32'($signed($urandom) >>> 10);
        span = 1023; fsc = 1; hyst = 255;
      end
      2: begin   // zero full scale, coefficients at maximum
        c = '{5{32'h7fffffff}};
        span = 0; fsc = 0;
      end
      3: begin   // coefficients at minimum
        c = '{5{32'h80000000}};
        span = 1023; fsc = 32767; hyst = 255;
      end
      4: begin   // every field random, upper bits exercise masking
        foreach (c[i]) c[i] = $urandom;
        span = $urandom; fsc = $urandom; hyst = $urandom;
      end
      5: begin
        c[1] = 32'($signed($urandom) >>> 12);
        span = $urandom_range(50, 1023); hyst = $urandom_range(1, 30);
      end
      default: ;
    endcase
    foreach (c[i]) reg_write(REG_COEF_1 + 3'(i), c[i]);
    reg_write(REG_SPAN, span);
    reg_write(REG_FULL_SCALE, fsc);
    reg_write(REG_HYST, hyst);
  endtask

  // Result checker: oldest expectation against each accepted result.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{heater_on, phase_done, temperature, setpoint_now};
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: heater %0b phase %0d temp %0d setpoint %0d",
                   heater_on, phase_done, temperature, setpoint_now);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp heater %0b phase %0d temp %0d setp %0d, got %0b %0d %0d %0d",
                     want.heater, want.ph, want.temp, want.setp,
                     heater_on, phase_done, temperature, setpoint_now);
        end
      end
    end
  end

  // Receiver stalls, changed at the falling edge.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = pick_gap();
      @(negedge clk);
      out_stall <= (n != 0);
      repeat ((n > 1) ? n - 1 : 0) @(negedge clk);
    end
  end

  // Watchdog: cycles in which nothing transfers.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    reading_t ofs_exp;
    rst = 1'b1; in_valid = 1'b0; sample = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    mismatches = 0; idle_cycles = 0; no_gaps = 1'b0;
    m_coef = '{32'sd26302009, 0, 0, 0, 0};
    m_span = 200; m_fsc = 30185; m_hyst = 0;
    m_phase = PH_OFS; m_ofs_cnt = 0; m_ofs_sum = 0; m_ofs_val = 0;
    m_setp = 0; m_cold = 0; m_temp = 0; m_heater = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Offset readings report zeros everywhere: typed in directly.
    ofs_exp = '{1'b0, PH_OFS, 18'sd0, 11'd0};
    for (int i = 0; i < NUM_DIR; i++)
      send_sample(DIR_SAMPLES[i], i < NUM_OFS, ofs_exp);

    for (int n = 0; n < NUM_SETTING; n++) begin
      wait_drained();
      apply_setting(n);
      for (int i = 0; i < RAND_PER; i++) begin
        if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
        send_sample(pick_sample(), 1'b0, ofs_exp);
      end
      no_gaps = 1'b0;
    end

    wait_drained();
    if (mismatches == 0 && pending_readings.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
